[src/sorted_glyph_table_search_core_assert.svh]
// Assertion macros for the sorted glyph table search core.
// Used by sorted_glyph_table_search_core.sv; expects clk_i and rst_ni in scope.
`ifndef SORTED_GLYPH_TABLE_SEARCH_CORE_ASSERT_SVH
`define SORTED_GLYPH_TABLE_SEARCH_CORE_ASSERT_SVH

// A property checked on every rising clock edge outside reset.
`define SGTS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// An antecedent that requires a consequent in the next cycle.
`define SGTS_ASSERT_NEXT(label, ante, cons, msg) \
  `SGTS_ASSERT(label, (ante) |=> (cons), msg)

`endif

[src/sgts_pkg.sv]
// Package for the sorted glyph table search core: field widths, op codes
// and the item payload type. No dependencies.
package sgts_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int CP_W  = 21;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;
  localparam int BOX_W = 12;
  localparam int ADV_W = 16;
  localparam int BRG_W = 16;
  localparam int OFF_W = 12;

  localparam int BOXMEM_W = 4 * BOX_W;
  localparam int METMEM_W = ADV_W + BRG_W + 2 * OFF_W;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } op_e;

  typedef struct packed {
    op_e                     op;
    logic [CP_W-1:0]         cp;
    logic [BOX_W-1:0]        box_x;
    logic [BOX_W-1:0]        box_y;
    logic [BOX_W-1:0]        box_w;
    logic [BOX_W-1:0]        box_h;
    logic [ADV_W-1:0]        advance;
    logic signed [BRG_W-1:0] bearing;
    logic signed [OFF_W-1:0] offset_x;
    logic signed [OFF_W-1:0] offset_y;
  } pay_t;

endpackage

[src/sorted_glyph_table_search_core.sv]
// Sorted glyph table with a fully pipelined binary search lookup.
// Depends on sgts_pkg and sorted_glyph_table_search_core_assert.svh.
//
// Usage: the input channel (in_valid_i / in_stall_o) carries one operation per
// transaction. A write (op 0) stores one glyph entry at entry_index and gives no
// result; an index at or beyond TABLE_DEPTH is dropped. A lookup (op 1) searches
// the first entry_count entries, which must be loaded in ascending codepoint
// order, and gives one result transaction on out_valid_o / out_stall_i with
// found and the entry's fields (all zero when not found).
// The search is one pipeline stage per probe, $clog2(TABLE_DEPTH+1) probes (11
// for 1024 entries), each stage owning its own copy of the key memory. A final
// stage reads the box and metric memories. One transaction is accepted every
// cycle unless a stalled result holds the pipeline.
// Writes travel down the pipeline and update each key copy as they pass, so a
// lookup always sees exactly the writes accepted before it.
// The user must write entry_count (cfg_we_i / cfg_wdata_i) only while the block
// is idle; the block does not enforce this. Reset clears entry_count and all
// valid bits; table contents are undefined until written. While the receiver
// stalls a pending result, the whole pipeline holds and in_stall_o is raised.
`include "sorted_glyph_table_search_core_assert.svh"

module sorted_glyph_table_search_core #(
  parameter int TABLE_DEPTH = sgts_pkg::TABLE_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sgts_pkg::CNT_W-1:0]        cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              op_i,
  input  logic [sgts_pkg::IDX_W-1:0]        entry_index_i,
  input  logic [sgts_pkg::CP_W-1:0]         codepoint_i,
  input  logic [sgts_pkg::BOX_W-1:0]        box_x_i,
  input  logic [sgts_pkg::BOX_W-1:0]        box_y_i,
  input  logic [sgts_pkg::BOX_W-1:0]        box_w_i,
  input  logic [sgts_pkg::BOX_W-1:0]        box_h_i,
  input  logic [sgts_pkg::ADV_W-1:0]        advance_i,
  input  logic signed [sgts_pkg::BRG_W-1:0] bearing_i,
  input  logic signed [sgts_pkg::OFF_W-1:0] offset_x_i,
  input  logic signed [sgts_pkg::OFF_W-1:0] offset_y_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic                              found_o,
  output logic [sgts_pkg::BOX_W-1:0]        hit_x_o,
  output logic [sgts_pkg::BOX_W-1:0]        hit_y_o,
  output logic [sgts_pkg::BOX_W-1:0]        hit_w_o,
  output logic [sgts_pkg::BOX_W-1:0]        hit_h_o,
  output logic [sgts_pkg::ADV_W-1:0]        hit_advance_o,
  output logic signed [sgts_pkg::BRG_W-1:0] hit_bearing_o,
  output logic signed [sgts_pkg::OFF_W-1:0] hit_offset_x_o,
  output logic signed [sgts_pkg::OFF_W-1:0] hit_offset_y_o
);
  import sgts_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int HW = $clog2(TABLE_DEPTH + 1);
  localparam int P  = HW;
  localparam int XW = (AW > IDX_W ? AW : IDX_W) + 1;
  localparam int CW = (HW > CNT_W ? HW : CNT_W) + 1;

  typedef struct packed {
    pay_t          pay;
    logic          wr_en;
    logic [AW-1:0] waddr;
    logic [HW-1:0] lo;
    logic [HW-1:0] hi;
    logic          act;
    logic [AW-1:0] mid;
    logic          done;
    logic [AW-1:0] hit;
  } stage_t;

  logic [CNT_W-1:0]    entry_count_q;
  logic                adv;
  logic                v_q     [P+1];
  stage_t              stg_q   [P+1];
  stage_t              stg_d0;
  stage_t              res     [P+1];
  stage_t              nxt     [P];
  logic                iss_act [P];
  logic [AW-1:0]       iss_mid [P];
  logic [CP_W-1:0]     key_mem [P][TABLE_DEPTH];
  logic [CP_W-1:0]     key_q   [1:P];
  logic [BOXMEM_W-1:0] box_mem [TABLE_DEPTH];
  logic [METMEM_W-1:0] met_mem [TABLE_DEPTH];
  logic [BOXMEM_W-1:0] box_rd_q;
  logic [METMEM_W-1:0] met_rd_q;
  logic                out_v_q;
  logic                out_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      entry_count_q <= cfg_wdata_i;
    end
  end

  // The whole pipeline moves together unless a finished result is stalled.
  assign adv        = !(out_v_q && out_stall_i);
  assign in_stall_o = !adv;

  always_comb begin
    stg_d0              = '0;
    stg_d0.pay.op       = op_e'(op_i);
    stg_d0.pay.cp       = codepoint_i;
    stg_d0.pay.box_x    = box_x_i;
    stg_d0.pay.box_y    = box_y_i;
    stg_d0.pay.box_w    = box_w_i;
    stg_d0.pay.box_h    = box_h_i;
    stg_d0.pay.advance  = advance_i;
    stg_d0.pay.bearing  = bearing_i;
    stg_d0.pay.offset_x = offset_x_i;
    stg_d0.pay.offset_y = offset_y_i;
    stg_d0.wr_en        = (op_e'(op_i) == OP_WRITE) &&
                          (XW'(entry_index_i) < XW'(TABLE_DEPTH));
    stg_d0.waddr        = AW'(entry_index_i);
    stg_d0.lo           = '0;
    stg_d0.hi           = (CW'(entry_count_q) > CW'(TABLE_DEPTH)) ?
                          HW'(TABLE_DEPTH) : HW'(entry_count_q);
  end

  // Each stage first resolves the probe whose key it just read, then issues
  // the next probe address from the updated bounds.
  always_comb begin
    stage_t r;
    res[0] = stg_q[0];
    for (int s = 1; s <= P; s++) begin
      r = stg_q[s];
      if (r.act && !r.done) begin
        if (key_q[s] == r.pay.cp) begin
          r.done = 1'b1;
          r.hit  = r.mid;
        end else if (key_q[s] < r.pay.cp) begin
          r.lo = HW'(r.mid) + HW'(1);
        end else begin
          r.hi = HW'(r.mid);
        end
      end
      res[s] = r;
    end
    for (int s = 0; s < P; s++) begin
      iss_act[s] = v_q[s] && (res[s].pay.op == OP_LOOKUP) && !res[s].done &&
                   (res[s].lo < res[s].hi);
      iss_mid[s] = AW'(res[s].lo + ((res[s].hi - res[s].lo) >> 1));
      nxt[s]     = res[s];
      nxt[s].act = iss_act[s];
      nxt[s].mid = iss_mid[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q     <= '{default: 1'b0};
      out_v_q <= 1'b0;
    end else if (adv) begin
      v_q[0] <= in_valid_i;
      for (int s = 0; s < P; s++) begin
        v_q[s+1] <= v_q[s];
      end
      out_v_q <= v_q[P] && (res[P].pay.op == OP_LOOKUP);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      stg_q[0] <= stg_d0;
      for (int s = 0; s < P; s++) begin
        stg_q[s+1] <= nxt[s];
      end
      out_found_q <= res[P].done;
    end
  end

  // One key copy per probe stage; a write updates the copy of the stage it
  // occupies, so ordering against lookups in flight is kept.
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int s = 0; s < P; s++) begin
        if (v_q[s] && stg_q[s].wr_en) begin
          key_mem[s][stg_q[s].waddr] <= stg_q[s].pay.cp;
        end
        key_q[s+1] <= key_mem[s][iss_mid[s]];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (v_q[P] && stg_q[P].wr_en) begin
        box_mem[stg_q[P].waddr] <= {stg_q[P].pay.box_h, stg_q[P].pay.box_w,
                                    stg_q[P].pay.box_y, stg_q[P].pay.box_x};
        met_mem[stg_q[P].waddr] <= {stg_q[P].pay.offset_y, stg_q[P].pay.offset_x,
                                    stg_q[P].pay.bearing, stg_q[P].pay.advance};
      end
      box_rd_q <= box_mem[res[P].hit];
      met_rd_q <= met_mem[res[P].hit];
    end
  end

  assign out_valid_o    = out_v_q;
  assign found_o        = out_found_q;
  assign hit_x_o        = out_found_q ? box_rd_q[BOX_W-1:0]         : '0;
  assign hit_y_o        = out_found_q ? box_rd_q[2*BOX_W-1:BOX_W]   : '0;
  assign hit_w_o        = out_found_q ? box_rd_q[3*BOX_W-1:2*BOX_W] : '0;
  assign hit_h_o        = out_found_q ? box_rd_q[4*BOX_W-1:3*BOX_W] : '0;
  assign hit_advance_o  = out_found_q ? met_rd_q[ADV_W-1:0] : '0;
  assign hit_bearing_o  = out_found_q ? signed'(met_rd_q[ADV_W+BRG_W-1:ADV_W]) : '0;
  assign hit_offset_x_o = out_found_q ?
                          signed'(met_rd_q[ADV_W+BRG_W+OFF_W-1:ADV_W+BRG_W]) : '0;
  assign hit_offset_y_o = out_found_q ?
                          signed'(met_rd_q[METMEM_W-1:ADV_W+BRG_W+OFF_W]) : '0;

  // A lookup that leaves the last probe without a match must have run out of range.
  `SGTS_ASSERT(a_search_exhausted,
               (v_q[P] && stg_q[P].pay.op == OP_LOOKUP && !res[P].done) |->
               (res[P].lo >= res[P].hi),
               "lookup left the probe stages with range not exhausted")
  `SGTS_ASSERT_NEXT(a_hit_reported,
                    adv && v_q[P] && stg_q[P].pay.op == OP_LOOKUP && res[P].done,
                    out_valid_o && found_o,
                    "resolved hit not reported as found")
  `SGTS_ASSERT_NEXT(a_write_silent,
                    adv && v_q[P] && stg_q[P].pay.op == OP_WRITE,
                    !out_valid_o,
                    "write transaction produced a result")
  `SGTS_ASSERT(a_no_stall_when_empty, !out_valid_o |-> !in_stall_o,
               "input stalled with no pending result")

endmodule

[test/tb_top.sv]
// Self-checking testbench for sorted_glyph_table_search_core: table loads,
// binary search lookups and entry_count settings under random handshake gaps.
// Depends on sgts_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_top;
  import sgts_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam int PIPE_LATENCY = $clog2(TABLE_DEPTH + 1) + 1;
  localparam int DRAIN_CYCLES = PIPE_LATENCY + 4;
  localparam int STUCK_LIMIT = 2000;
  localparam logic [CP_W-1:0] KEY_MAX = {CP_W{1'b1}};

  typedef struct packed {
    logic [CP_W-1:0]         key;
    logic [BOX_W-1:0]        x;
    logic [BOX_W-1:0]        y;
    logic [BOX_W-1:0]        w;
    logic [BOX_W-1:0]        h;
    logic [ADV_W-1:0]        adv;
    logic signed [BRG_W-1:0] brg;
    logic signed [OFF_W-1:0] ox;
    logic signed [OFF_W-1:0] oy;
  } glyph_t;

  typedef struct packed {
    op_e             op;
    logic [IDX_W-1:0] idx;
    glyph_t          g;
  } glyph_op_t;

  typedef struct packed {
    logic                    found;
    logic [BOX_W-1:0]        x;
    logic [BOX_W-1:0]        y;
    logic [BOX_W-1:0]        w;
    logic [BOX_W-1:0]        h;
    logic [ADV_W-1:0]        adv;
    logic signed [BRG_W-1:0] brg;
    logic signed [OFF_W-1:0] ox;
    logic signed [OFF_W-1:0] oy;
  } hit_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  op_e op_sel = OP_WRITE;
  logic [IDX_W-1:0] entry_index = '0;
  logic [CP_W-1:0] codepoint = '0;
  logic [BOX_W-1:0] box_x = '0;
  logic [BOX_W-1:0] box_y = '0;
  logic [BOX_W-1:0] box_w = '0;
  logic [BOX_W-1:0] box_h = '0;
  logic [ADV_W-1:0] advance = '0;
  logic signed [BRG_W-1:0] bearing = '0;
  logic signed [OFF_W-1:0] offset_x = '0;
  logic signed [OFF_W-1:0] offset_y = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic found;
  logic [BOX_W-1:0] hit_x;
  logic [BOX_W-1:0] hit_y;
  logic [BOX_W-1:0] hit_w;
  logic [BOX_W-1:0] hit_h;
  logic [ADV_W-1:0] hit_advance;
  logic signed [BRG_W-1:0] hit_bearing;
  logic signed [OFF_W-1:0] hit_offset_x;
  logic signed [OFF_W-1:0] hit_offset_y;

  // Predictor state: the glyph table as the block should hold it.
  glyph_t glyph_store [TABLE_DEPTH];
  logic [CNT_W-1:0] count_reg = '0;
  hit_t expected_hits[$];
  hit_t head_hit;

  int in_idle_pct = 0;
  int out_stall_pct = 0;
  int error_count = 0;
  int write_count = 0;
  int lookup_count = 0;
  int hit_count = 0;
  int stuck_cycles = 0;

  sorted_glyph_table_search_core uut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .op_i           (op_sel),
    .entry_index_i  (entry_index),
    .codepoint_i    (codepoint),
    .box_x_i        (box_x),
    .box_y_i        (box_y),
    .box_w_i        (box_w),
    .box_h_i        (box_h),
    .advance_i      (advance),
    .bearing_i      (bearing),
    .offset_x_i     (offset_x),
    .offset_y_i     (offset_y),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .found_o        (found),
    .hit_x_o        (hit_x),
    .hit_y_o        (hit_y),
    .hit_w_o        (hit_w),
    .hit_h_o        (hit_h),
    .hit_advance_o  (hit_advance),
    .hit_bearing_o  (hit_bearing),
    .hit_offset_x_o (hit_offset_x),
    .hit_offset_y_o (hit_offset_y)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < out_stall_pct);
  end

  // Binary search exactly as the block probes: lo/hi halving over the
  // first entry_count slots, saturated at the table depth.
  function automatic hit_t search_glyph(input logic [CP_W-1:0] key);
    hit_t r;
    int lo;
    int hi;
    int mid;
    int hit_slot;
    r = '0;
    lo = 0;
    hi = (count_reg > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_reg);
    hit_slot = -1;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (glyph_store[mid].key == key) begin
        hit_slot = mid;
        break;
      end
      if (glyph_store[mid].key < key) lo = mid + 1;
      else hi = mid;
    end
    if (hit_slot >= 0) begin
      r.found = 1'b1;
      r.x = glyph_store[hit_slot].x;
      r.y = glyph_store[hit_slot].y;
      r.w = glyph_store[hit_slot].w;
      r.h = glyph_store[hit_slot].h;
      r.adv = glyph_store[hit_slot].adv;
      r.brg = glyph_store[hit_slot].brg;
      r.ox = glyph_store[hit_slot].ox;
      r.oy = glyph_store[hit_slot].oy;
    end
    return r;
  endfunction

  function automatic glyph_t random_glyph(input logic [CP_W-1:0] key);
    glyph_t g;
    g.key = key;
    g.x = BOX_W'($urandom);
    g.y = BOX_W'($urandom);
    g.w = BOX_W'($urandom);
    g.h = BOX_W'($urandom);
    g.adv = ADV_W'($urandom);
    g.brg = BRG_W'($urandom);
    g.ox = OFF_W'($urandom);
    g.oy = OFF_W'($urandom);
    return g;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    error_count++;
    if (error_count <= 40) begin
      $display("mismatch on %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
    end
  endtask

  task automatic check_field(input string what, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // Results are compared on the falling edge before the rising edge that takes them.
  always @(negedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        report_mismatch("result with no lookup pending", {31'b0, found}, 32'b0);
      end else begin
        head_hit = expected_hits.pop_front();
        check_field("found", 32'(found), 32'(head_hit.found));
        check_field("hit_x", 32'(hit_x), 32'(head_hit.x));
        check_field("hit_y", 32'(hit_y), 32'(head_hit.y));
        check_field("hit_w", 32'(hit_w), 32'(head_hit.w));
        check_field("hit_h", 32'(hit_h), 32'(head_hit.h));
        check_field("hit_advance", 32'(hit_advance), 32'(head_hit.adv));
        check_field("hit_bearing", 32'(hit_bearing), 32'(head_hit.brg));
        check_field("hit_offset_x", 32'(hit_offset_x), 32'(head_hit.ox));
        check_field("hit_offset_y", 32'(hit_offset_y), 32'(head_hit.oy));
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles = 0;
    end else begin
      stuck_cycles++;
      if (stuck_cycles >= STUCK_LIMIT) begin
        $display("no transaction for %0d cycles, %0d results outstanding",
                 stuck_cycles, expected_hits.size());
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  task automatic set_traffic(input int idle_pct, input int stall_pct);
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
  endtask

  // Drive one operation and hold it until the block takes it, then update
  // the predictor. The valid is left high for a back-to-back follower.
  task automatic send_glyph_op(input glyph_op_t item);
    bit taken;
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op_sel <= item.op;
    entry_index <= item.idx;
    codepoint <= item.g.key;
    box_x <= item.g.x;
    box_y <= item.g.y;
    box_w <= item.g.w;
    box_h <= item.g.h;
    advance <= item.g.adv;
    bearing <= item.g.brg;
    offset_x <= item.g.ox;
    offset_y <= item.g.oy;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (item.op == OP_WRITE) begin
      glyph_store[item.idx] = item.g;
      write_count++;
    end else begin
      expected_hits.push_back(search_glyph(item.g.key));
      if (expected_hits[$].found) hit_count++;
      lookup_count++;
    end
  endtask

  task automatic write_glyph(input int slot, input glyph_t g);
    glyph_op_t item;
    item.op = OP_WRITE;
    item.idx = IDX_W'(slot);
    item.g = g;
    send_glyph_op(item);
  endtask

  task automatic lookup_glyph(input logic [CP_W-1:0] key);
    glyph_op_t item;
    item.op = OP_LOOKUP;
    item.idx = IDX_W'($urandom);
    item.g = random_glyph(key);
    send_glyph_op(item);
  endtask

  // Waits until every lookup has answered and queued writes have drained.
  task automatic wait_idle();
    @(posedge clk);
    while (expected_hits.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_count(input int value);
    in_valid <= 1'b0;
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= CNT_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    count_reg = CNT_W'(value);
  endtask

  task automatic test_directed();
    logic [CP_W-1:0] keys [8];
    glyph_t g;
    set_traffic(0, 0);
    keys = '{21'd0, 21'd1, 21'd100, 21'h400, 21'h8000, 21'h10000, KEY_MAX - 21'd1, KEY_MAX};
    // An empty table must miss without probing anything.
    write_entry_count(0);
    lookup_glyph(21'd0);
    for (int i = 0; i < 8; i++) begin
      g.key = keys[i];
      if (i % 2 == 0) begin
        g.x = '1; g.y = '1; g.w = '1; g.h = '1; g.adv = '1;
        g.brg = 16'sh7fff; g.ox = 12'sh7ff; g.oy = 12'sh7ff;
      end else begin
        g.x = '0; g.y = '0; g.w = '0; g.h = '0; g.adv = '0;
        g.brg = 16'sh8000; g.ox = 12'sh800; g.oy = 12'sh800;
      end
      write_glyph(i, g);
    end
    write_entry_count(8);
    lookup_glyph(21'd0);
    lookup_glyph(KEY_MAX);
    lookup_glyph(21'd100);
    lookup_glyph(21'h8000);
    lookup_glyph(21'd2);
    lookup_glyph(KEY_MAX - 21'd2);
    // With one valid entry only slot zero may match.
    write_entry_count(1);
    lookup_glyph(21'd0);
    lookup_glyph(21'd1);
    // Break the ordering in the middle; the probes decide what matches.
    write_entry_count(8);
    write_glyph(4, random_glyph(21'd5));
    lookup_glyph(21'd5);
    lookup_glyph(21'h400);
  endtask

  task automatic test_full_table();
    int key;
    int slot;
    set_traffic(63, 0);
    key = 0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (i == TABLE_DEPTH - 1) key = int'(KEY_MAX);
      write_glyph(i, random_glyph(CP_W'(key)));
      key += $urandom_range(1, 2040);
    end
    write_entry_count(TABLE_DEPTH);
    set_traffic(0, 63);
    for (int i = 0; i < 40; i++) begin
      slot = $urandom_range(0, TABLE_DEPTH - 1);
      if ($urandom_range(0, 3) == 0) lookup_glyph(CP_W'($urandom));
      else lookup_glyph(glyph_store[slot].key);
    end
    // Counts beyond the depth saturate.
    write_entry_count((1 << CNT_W) - 1);
    set_traffic(17, 17);
    lookup_glyph(21'd0);
    lookup_glyph(KEY_MAX);
    for (int i = 0; i < 38; i++) begin
      slot = $urandom_range(0, TABLE_DEPTH - 1);
      if ($urandom_range(0, 3) == 0) lookup_glyph(glyph_store[slot].key + 21'd1);
      else lookup_glyph(glyph_store[slot].key);
    end
  endtask

  // Small sorted tables with random content, occasional duplicate keys,
  // counts that differ from the loaded size and stray unsorted writes.
  task automatic test_random_tables();
    int n;
    int key;
    int slot;
    int pick;
    int count_val;
    for (int r = 0; r < 12; r++) begin
      case (r % 4)
        0: begin set_traffic(0, 0); end
        1: begin set_traffic(63, 0); end
        2: begin set_traffic(0, 63); end
        default: begin set_traffic(17, 17); end
      endcase
      n = (r < 2) ? r + 1 : $urandom_range(3, 24);
      key = $urandom_range(0, int'(KEY_MAX) - 24 * 4096);
      for (int i = 0; i < n; i++) begin
        write_glyph(i, random_glyph(CP_W'(key)));
        key += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, 4096);
      end
      pick = $urandom_range(0, 99);
      if (pick < 70) count_val = n;
      else if (pick < 85) count_val = $urandom_range(0, n);
      else count_val = $urandom_range(n, TABLE_DEPTH);
      write_entry_count(count_val);
      for (int i = 0; i < 12; i++) begin
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, n - 1);
        if (pick < 10) write_glyph(slot, random_glyph(CP_W'($urandom)));
        else if (pick < 70) lookup_glyph(glyph_store[slot].key);
        else if (pick < 85) lookup_glyph(glyph_store[slot].key + 21'd1);
        else lookup_glyph(CP_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_full_table();
    test_random_tables();
    in_valid <= 1'b0;
    wait_idle();
    $display("covered %0d table writes and %0d lookups (%0d hits, %0d misses)",
             write_count, lookup_count, hit_count, lookup_count - hit_count);
    $display("entry_count ran from 0 through full depth and saturation; %0d mismatches",
             error_count);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
